// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the prime gap block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, quiet while reset is low.
`define TDPG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next rising edge.
`define TDPG_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// File: hdl/tdpg_pkg.sv
// Shared widths, types and constants of the trial division prime gap block.
package tdpg_pkg;

    localparam int NUM_BITS   = 31;
    localparam int S_TDATA_W  = ((NUM_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((2 * NUM_BITS + 1 + 7) / 8) * 8;
    localparam int DIV_CNT_W  = $clog2(NUM_BITS);

    typedef logic [NUM_BITS-1:0] word_t;

    localparam word_t WORD_MAX    = '1;
    localparam word_t FIRST_ODD   = word_t'(3);
    localparam word_t SMALL_PRIME = word_t'(2);
    localparam word_t DIV_STEP    = word_t'(2);

    // Request to the serial divider.
    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    // Answer from the serial divider; done pulses for one cycle.
    typedef struct packed {
        logic  done;
        word_t quotient;
        word_t remainder;
    } div_rsp_t;

endpackage

// File: hdl/tdpg_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module tdpg_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  tdpg_pkg::div_req_t div_req,
    output tdpg_pkg::div_rsp_t div_rsp
);
    import tdpg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    word_t                rem_reg, rem_next;
    word_t                quo_reg, quo_next;
    word_t                dvs_reg, dvs_next;
    logic [NUM_BITS:0]    rem_shift;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_shift = {rem_reg, quo_reg[NUM_BITS-1]};
        if (busy_reg) begin
            // bring down the next dividend bit, subtract when it fits
            if (rem_shift >= {1'b0, dvs_reg}) begin
                rem_next = word_t'(rem_shift - {1'b0, dvs_reg});
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[NUM_BITS-1:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (div_req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(NUM_BITS - 1);
            rem_next  = '0;
            quo_next  = div_req.dividend;
            dvs_next  = div_req.divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign div_rsp.done      = done_reg;
    assign div_rsp.quotient  = quo_reg;
    assign div_rsp.remainder = rem_reg;

endmodule

// File: hdl/trial_division_prime_gap.sv
// Top level of the trial division primality test with prime gaps and a prime count.
// Each request on the s_ side carries one candidate; each gives exactly one
// result on the m_ side: whether the candidate is prime (exactly two divisors,
// so 0 and 1 are not and 2 is), the gap to the previous prime (or to range_start
// before the first prime, 0 for a non-prime) and the saturating count of primes
// found so far. Candidates below 3 and even candidates are settled without the
// divider. An odd candidate n runs the odd trial divisors d = 3, 5, ... through a
// bit-serial restoring divider, one quotient bit per cycle; the search stops at
// the first divisor that divides n or exceeds n / d, so a prime n runs through
// every odd divisor up to its square root. One candidate is worked on at a time;
// the finished result sits in an output register, so the next request is taken
// while the result waits. range_start is written through cfg_wr_en / cfg_wr_data;
// the user must write it only while the block is idle, which the block does not enforce.
`include "assert_macros.svh"

module trial_division_prime_gap (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: range_start
    input  logic                           cfg_wr_en,
    input  tdpg_pkg::word_t                cfg_wr_data,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tdpg_pkg::S_TDATA_W-1:0] s_tdata,   // [30:0] candidate, rest zero
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tdpg_pkg::M_TDATA_W-1:0] m_tdata    // [0] is_prime, [31:1] gap,
                                                      // [62:32] prime_count, [63] zero
);
    import tdpg_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t   state_reg, state_next;
    word_t    range_start_reg, range_start_next;
    word_t    last_prime_reg, last_prime_next;
    word_t    found_count_reg, found_count_next;
    word_t    cand_reg, cand_next;
    word_t    divisor_reg, divisor_next;
    logic     prime_reg, prime_next;
    logic     div_start_reg, div_start_next;
    logic     m_tvalid_reg, m_tvalid_next;
    logic     m_prime_reg, m_prime_next;
    word_t    m_gap_reg, m_gap_next;
    word_t    m_count_reg, m_count_next;

    div_req_t div_req;
    div_rsp_t div_rsp;
    word_t    s_cand;
    word_t    gap_ref;
    logic     out_free;

    logic     gap_ok;
    logic     count_ok;
    logic     div_ok;
    logic     count_live;

    assign s_cand   = s_tdata[NUM_BITS-1:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign gap_ref  = (found_count_reg == '0) ? range_start_reg : last_prime_reg;

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = cand_reg;
    assign div_req.divisor  = divisor_reg;

    tdpg_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    always_comb begin
        state_next       = state_reg;
        range_start_next = range_start_reg;
        last_prime_next  = last_prime_reg;
        found_count_next = found_count_reg;
        cand_next        = cand_reg;
        divisor_next     = divisor_reg;
        prime_next       = prime_reg;
        div_start_next   = 1'b0;
        m_tvalid_next    = m_tvalid_reg;
        m_prime_next     = m_prime_reg;
        m_gap_next       = m_gap_reg;
        m_count_next     = m_count_reg;

        if (cfg_wr_en) begin
            range_start_next = cfg_wr_data;
        end

        // drop the result once the sink takes it
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cand_next = s_cand;
                    if (s_cand < SMALL_PRIME) begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end else if (s_cand == SMALL_PRIME) begin
                        prime_next = 1'b1;
                        state_next = ST_FINISH;
                    end else if (!s_cand[0]) begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        // odd candidate: start trial division at 3
                        divisor_next   = FIRST_ODD;
                        div_start_next = 1'b1;
                        state_next     = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    if (divisor_reg > div_rsp.quotient) begin
                        // divisor passed the square root: no factor exists
                        prime_next = 1'b1;
                        state_next = ST_FINISH;
                    end else if (div_rsp.remainder == '0) begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        // advance to the next odd divisor
                        divisor_next   = divisor_reg + DIV_STEP;
                        div_start_next = 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                // hold the result until the output register is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_prime_next  = prime_reg;
                    if (prime_reg) begin
                        m_gap_next      = cand_reg - gap_ref;
                        last_prime_next = cand_reg;
                        if (found_count_reg != WORD_MAX) begin
                            found_count_next = found_count_reg + word_t'(1);
                            m_count_next     = found_count_reg + word_t'(1);
                        end else begin
                            m_count_next = found_count_reg;
                        end
                    end else begin
                        m_gap_next   = '0;
                        m_count_next = found_count_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            range_start_reg <= '0;
            found_count_reg <= '0;
            div_start_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            range_start_reg <= range_start_next;
            found_count_reg <= found_count_next;
            div_start_reg   <= div_start_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        last_prime_reg <= last_prime_next;
        cand_reg       <= cand_next;
        divisor_reg    <= divisor_next;
        prime_reg      <= prime_next;
        m_prime_reg    <= m_prime_next;
        m_gap_reg      <= m_gap_next;
        m_count_reg    <= m_count_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        m_tdata                           = '0;
        m_tdata[0]                        = m_prime_reg;
        m_tdata[NUM_BITS:1]               = m_gap_reg;
        m_tdata[2*NUM_BITS:NUM_BITS+1]    = m_count_reg;
    end

    assign gap_ok     = !m_tvalid_reg || m_prime_reg || (m_gap_reg == '0);
    assign count_ok   = !m_tvalid_reg || !m_prime_reg || (m_count_reg != '0);
    assign div_ok     = !div_rsp.done || (state_reg == ST_DIVIDE);
    assign count_live = (found_count_reg != '0);

    // a non-prime result carries no gap
    `TDPG_ASSERT(a_gap_zero, aclk, aresetn, gap_ok, "gap set on non-prime")
    // a prime result always carries a nonzero count
    `TDPG_ASSERT(a_count_prime, aclk, aresetn, count_ok, "prime with zero count")
    // the divider answers only while a trial division is running
    `TDPG_ASSERT(a_div_state, aclk, aresetn, div_ok, "divider done outside divide")
    // the prime count never returns to zero
    `TDPG_ASSERT_NEXT(a_count_keep, aclk, aresetn, count_live, count_live, "prime count cleared")

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the trial division prime gap block.
`timescale 1ns / 1ps

module testbench;
    import tdpg_pkg::*;

    // One large prime near 2^31 keeps the block busy through its whole divisor search
    // without any handshake; the limit must cover that search before giving up.
    localparam int unsigned IDLE_LIMIT    = 3_000_000;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned RANDOM_ITEMS  = 100;
    // Largest k such that 3 * k still fits in a candidate.
    localparam int unsigned MAX_TRIPLE_K  = 715_827_882;

    // Expected content of one result beat.
    typedef struct {
        logic  is_prime;
        word_t gap;
        word_t prime_count;
    } prime_result_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    word_t                cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Local copy of the block's register and state, advanced per accepted request.
    word_t cfg_range_start = '0;
    word_t last_prime      = '0;
    word_t primes_found    = '0;

    prime_result_t pending_results[$];

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned idle_cycles    = 0;
    int unsigned burst_left     = 0;
    bit          sender_paced   = 1'b1;
    int unsigned ready_run      = 0;
    int unsigned stall_run      = 0;

    trial_division_prime_gap u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Exactly two divisors: odd trial divisors up to the square root.
    function automatic bit has_two_divisors(word_t n);
        longint unsigned value;
        longint unsigned d;
        value = n;
        if (value < 2)
            return 1'b0;
        if (value == 2)
            return 1'b1;
        if (value % 2 == 0)
            return 1'b0;
        for (d = 3; d <= value / d; d += 2) begin
            if (value % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Work out the result of one candidate and advance the local state.
    function automatic prime_result_t predict_prime_gap(word_t cand);
        prime_result_t res;
        word_t         reference;
        res.is_prime    = has_two_divisors(cand);
        res.gap         = '0;
        if (res.is_prime) begin
            // Before the first prime the register is the reference, whatever
            // was written last; afterwards it is never looked at again.
            reference  = (primes_found == '0) ? cfg_range_start : last_prime;
            res.gap    = cand - reference;      // wraps at the word width
            last_prime = cand;
            if (primes_found != WORD_MAX)
                primes_found = primes_found + 1'b1;
        end
        res.prime_count = primes_found;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void flag_mismatch(string what, longint unsigned want,
                                          longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch at result %0d, %s: expected %0d, got %0d",
                     results_seen, what, want, got);
    endfunction

    function automatic void check_prime_result(logic [M_TDATA_W-1:0] beat);
        prime_result_t want;
        logic          got_prime;
        word_t         got_gap;
        word_t         got_count;
        got_prime = beat[0];
        got_gap   = beat[NUM_BITS:1];
        got_count = beat[2*NUM_BITS:NUM_BITS+1];
        results_seen++;
        if (pending_results.size() == 0) begin
            flag_mismatch("result with no request pending", 0, beat);
            return;
        end
        want = pending_results.pop_front();
        if (got_prime !== want.is_prime)
            flag_mismatch("is_prime", want.is_prime, got_prime);
        if (got_gap !== want.gap)
            flag_mismatch("gap", want.gap, got_gap);
        if (got_count !== want.prime_count)
            flag_mismatch("prime_count", want.prime_count, got_count);
    endfunction

    // Sample results at the rising edge, before the block updates its outputs.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_prime_result(m_tdata);
    end

    // Drop the run if neither side moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("[trial_division_prime_gap] ERROR");
                $finish;
            end
        end
    end

    // Receiver: pick short or long ready runs at random, with a stall of random
    // length before each; a zero-length stall gives stretches with no back-pressure.
    always @(negedge aclk) begin
        if (stall_run != 0) begin
            stall_run <= stall_run - 1;
            m_tready  <= 1'b0;
        end else if (ready_run != 0) begin
            ready_run <= ready_run - 1;
            m_tready  <= 1'b1;
        end else begin
            ready_run <= $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(20, 60);
            stall_run <= $urandom_range(0, 6);
            m_tready  <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Hold one request until it is accepted, then record its expected result.
    // In paced mode, drop valid for a random gap at the start of each burst.
    task automatic send_candidate(word_t cand);
        int unsigned gap_len;
        if (sender_paced) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                gap_len    = $urandom_range(1, 10);
                @(negedge aclk) s_tvalid <= 1'b0;
                repeat (gap_len - 1) @(negedge aclk);
            end
            burst_left--;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(cand);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_results.push_back(predict_prime_gap(cand));
    endtask

    // Stop sending and wait until every pending result has come back.
    task automatic drain_results();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Write range_start while the block is idle.
    task automatic write_range_start(word_t value);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk) cfg_wr_en <= 1'b0;
        cfg_range_start = value;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Before the first prime the gap is taken from range_start as last
    // written; the first prime here lies below it, so the gap wraps.
    task automatic test_range_start_reference();
        write_range_start(WORD_MAX);
        send_candidate(word_t'(0));
        send_candidate(word_t'(1));
        send_candidate(word_t'(4));
        send_candidate(word_t'(9));
        write_range_start(word_t'(5));
        send_candidate(word_t'(2));
    endtask

    // Small primes, small composites and squares of primes at the edge of
    // the divisor search.
    task automatic test_small_numbers();
        write_range_start('0);
        send_candidate(word_t'(3));
        send_candidate(word_t'(5));
        send_candidate(word_t'(6));
        send_candidate(word_t'(7));
        send_candidate(word_t'(15));
        send_candidate(word_t'(25));
        send_candidate(word_t'(49));
        send_candidate(word_t'(97));
        send_candidate(word_t'(121));
    endtask

    // Full-width candidates: the largest word is prime and takes the longest
    // search; a prime below it afterwards gives a wrapped gap.
    task automatic test_wide_values();
        send_candidate(WORD_MAX - 1);
        send_candidate(WORD_MAX - 2);
        send_candidate(word_t'(31'h2AAA_AAAB));
        // hold the sender until the block has caught up
        drain_results();
        send_candidate(WORD_MAX);
        send_candidate(word_t'(2));
        send_candidate(word_t'(31'h5555_5555));
    endtask

    // Mostly ascending walks over small numbers, as a feeder stepping through
    // a range gives; the rest are wide composites that end quickly and small
    // candidates out of order.
    task automatic test_random_stream(int unsigned n_items);
        word_t       walk;
        word_t       big;
        int unsigned pick;
        int unsigned i;
        walk = word_t'($urandom_range(0, 255));
        for (i = 0; i < n_items; i++) begin
            if (i == n_items / 2)
                write_range_start(word_t'($urandom));
            // run a stretch with the sender never idle
            sender_paced = !(i >= 30 && i < 50);
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                walk = walk + word_t'($urandom_range(1, 24));
                if (walk > 4000)
                    walk = word_t'($urandom_range(0, 64));
                send_candidate(walk);
            end else if (pick < 90) begin
                if ($urandom_range(0, 1)) begin
                    big    = word_t'($urandom);
                    big[0] = 1'b0;
                end else begin
                    big = word_t'(3 * $urandom_range(2, MAX_TRIPLE_K));
                end
                send_candidate(big);
            end else begin
                send_candidate(word_t'($urandom_range(0, 4095)));
            end
        end
        sender_paced = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_range_start_reference();
        test_small_numbers();
        test_wide_values();
        test_random_stream(RANDOM_ITEMS);

        drain_results();
        repeat (64) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[trial_division_prime_gap] OK");
        end else begin
            $display("[trial_division_prime_gap] ERROR");
        end
        $finish;
    end

endmodule
